// ----- hw/rtl/swapl_pkg.sv -----
// Package for the sensor window average, peak and log unit.
// Holds the field widths and the parameter defaults.
// Depends on nothing; the interfaces, the top level and the checker import it.
package swapl_pkg;

  // Field widths of the input and result words
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned HUM_W  = 14;
  localparam int unsigned ALT_W  = 16;
  localparam int unsigned PEAK_W = 14;
  localparam int unsigned SLOT_W = 7;

  // Parameter defaults
  localparam int unsigned WINDOW_DEF    = 1024;
  localparam int unsigned LOG_DEPTH_DEF = 128;

endpackage

// ----- hw/rtl/swapl_if.sv -----
// Handshake interfaces for the sample and result channels.
// Depends on swapl_pkg for the field widths.
interface swapl_in_if;
  import swapl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic        [HUM_W-1:0]  humidity;
  logic signed [ALT_W-1:0]  altitude;

  modport source (output valid, temperature, humidity, altitude, input ready);
  modport sink   (input valid, temperature, humidity, altitude, output ready);
endinterface

interface swapl_out_if;
  import swapl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] avg_temperature;
  logic        [HUM_W-1:0]  avg_humidity;
  logic        [PEAK_W-1:0] peak_temperature;
  logic        [PEAK_W-1:0] peak_humidity;
  logic                     log_written;
  logic        [SLOT_W-1:0] log_slot;

  modport source (output valid, avg_temperature, avg_humidity, peak_temperature,
                  peak_humidity, log_written, log_slot, input ready);
  modport sink   (input valid, avg_temperature, avg_humidity, peak_temperature,
                  peak_humidity, log_written, log_slot, output ready);
endinterface

// ----- hw/rtl/swapl_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module swapl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/swapl_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; the top level runs two of them side by side.
module swapl_div #(
  parameter int unsigned DIV_W = 25,
  parameter int unsigned VW    = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [VW-1:0]    divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [VW-1:0]    dsr_q, dsr_d;
  logic [VW:0]      rem_sh;
  logic [VW:0]      rem_nx;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d = CW'(DIV_W);
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      // shift one dividend bit in, retire one quotient bit
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = rem_nx[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/sensor_window_average_peak_log_unit.sv -----
// Sensor window average, peak and altitude log unit: top level.
// An accepted sample word passes through S_SUM, S_START, S_DIV (the bit-serial mean
// dividers) and S_OUT into the registered result word; a new sample word is taken
// only back in S_IDLE, once the result word is loaded, so one is in flight at a time.
// Reset (rst_ni low, asynchronous): sums, peaks, fill count and log index clear;
// window and log RAMs keep their contents; a stale window entry is read but never used.
module sensor_window_average_peak_log_unit #(
  parameter int unsigned WINDOW    = swapl_pkg::WINDOW_DEF,
  parameter int unsigned LOG_DEPTH = swapl_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swapl_in_if.sink    in_i,
  swapl_out_if.source out_o
);
  import swapl_pkg::*;

  // Derived widths
  localparam int unsigned LOG_W = $clog2(WINDOW);
  localparam int unsigned PW    = (WINDOW > 1) ? LOG_W : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned TS_W  = TEMP_W + LOG_W;     // signed temperature sum
  localparam int unsigned HS_W  = HUM_W + LOG_W;      // unsigned humidity sum
  localparam int unsigned DIV_W = TS_W;               // holds either magnitude
  localparam int unsigned LN_W  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned LA_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned WIN_DW = TEMP_W + HUM_W;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0; // wait for a sample word, launch the ring read
  localparam logic [2:0] S_SUM   = 3'd1; // old entry is back: update sums, peaks, log
  localparam logic [2:0] S_START = 3'd2; // launch both dividers
  localparam logic [2:0] S_DIV   = 3'd3; // wait for the quotients
  localparam logic [2:0] S_OUT   = 3'd4; // hand the result word to the output register

  logic [2:0] state_q, state_d;

  // Captured sample
  logic signed [TEMP_W-1:0] t_q;
  logic        [HUM_W-1:0]  h_q;
  logic signed [ALT_W-1:0]  alt_q;

  // Block state
  logic [PW-1:0]           pos_q, pos_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic signed [TS_W-1:0]  tsum_q, tsum_d;
  logic [HS_W-1:0]         hsum_q, hsum_d;
  logic [PEAK_W-1:0]       peak_t_q, peak_t_d;
  logic [PEAK_W-1:0]       peak_h_q, peak_h_d;
  logic [LN_W-1:0]         log_next_q, log_next_d;

  // Per-item log outcome, held until the result word is built
  logic              wr_q;
  logic [SLOT_W-1:0] slot_q;
  logic              tneg_q;

  // Output register
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] avg_t_q;
  logic        [HUM_W-1:0]  avg_h_q;
  logic        [PEAK_W-1:0] out_peak_t_q;
  logic        [PEAK_W-1:0] out_peak_h_q;
  logic                     out_wr_q;
  logic        [SLOT_W-1:0] out_slot_q;

  logic in_acc;
  logic out_load;
  logic full;
  logic log_hit;
  logic div_start;
  logic div_t_busy, div_h_busy;
  logic [DIV_W-1:0] dvd_t, dvd_h;
  logic [DIV_W-1:0] quo_t, quo_h;
  logic [DIV_W-1:0] avg_t_full;
  logic [WIN_DW-1:0] win_rdata;
  logic signed [TEMP_W-1:0] old_t;
  logic [HUM_W-1:0]         old_h;
  logic signed [TS_W-1:0]   sub_t;
  logic [HS_W-1:0]          sub_h;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // ------------------------------------------------------------------
  // Sample ring: one entry per window position, temperature over humidity.
  // Read the entry about to be replaced on accept, write the new sample in its place in S_SUM.
  // An entry is only used once the ring is full, so every entry that is used
  // has been written and no clearing pass is needed.
  // ------------------------------------------------------------------
  swapl_ram #(
    .WIDTH (WIN_DW),
    .DEPTH (WINDOW)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SUM),
    .waddr_i (pos_q),
    .wdata_i ({t_q, h_q}),
    .re_i    (in_acc),
    .raddr_i (pos_q),
    .rdata_o (win_rdata)
  );

  // ------------------------------------------------------------------
  // Altitude log: slots fill strictly in order, so the written flags are
  // exactly the slots below log_next_q; no per-slot flag storage is kept.
  // Nothing inside the block reads the log back.
  // ------------------------------------------------------------------
  swapl_ram #(
    .WIDTH (WIN_DW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_SUM) && log_hit),
    .waddr_i (log_next_q[LA_W-1:0]),
    .wdata_i ({t_q, h_q}),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  // ------------------------------------------------------------------
  // Sum, peak and log update (S_SUM)
  // ------------------------------------------------------------------
  always_comb begin
    full  = (fill_q == CNT_W'(WINDOW));
    old_t = signed'(win_rdata[WIN_DW-1:HUM_W]);
    old_h = win_rdata[HUM_W-1:0];
    // drop the oldest sample only once the ring has wrapped
    sub_t = full ? TS_W'(old_t) : '0;
    sub_h = full ? HS_W'(old_h) : '0;
    tsum_d = tsum_q - sub_t + TS_W'(t_q);
    hsum_d = hsum_q - sub_h + HS_W'(h_q);
    fill_d = full ? fill_q : (fill_q + 1'b1);
    pos_d  = (pos_q == PW'(WINDOW - 1)) ? '0 : (pos_q + 1'b1);

    // negative temperatures never lift the peak
    peak_t_d = (!t_q[TEMP_W-1] && (t_q[PEAK_W-1:0] > peak_t_q)) ? t_q[PEAK_W-1:0]
                                                                  : peak_t_q;
    peak_h_d = (PEAK_W'(h_q) > peak_h_q) ? PEAK_W'(h_q) : peak_h_q;

    // log when altitude is strictly above the next slot index and room is left
    log_hit = !alt_q[ALT_W-1]
              && (ALT_W'(alt_q[ALT_W-2:0]) > ALT_W'(log_next_q))
              && (log_next_q < LN_W'(LOG_DEPTH));
    log_next_d = log_hit ? (log_next_q + 1'b1) : log_next_q;
  end

  // ------------------------------------------------------------------
  // Mean dividers: magnitude of each sum over the fill count
  // ------------------------------------------------------------------
  assign div_start = (state_q == S_START);
  assign dvd_t     = tsum_q[TS_W-1] ? DIV_W'(unsigned'(-tsum_q)) : DIV_W'(unsigned'(tsum_q));
  assign dvd_h     = DIV_W'(hsum_q);

  swapl_div #(
    .DIV_W (DIV_W),
    .VW    (CNT_W)
  ) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_t),
    .divisor_i  (fill_q),
    .busy_o     (div_t_busy),
    .quotient_o (quo_t)
  );

  swapl_div #(
    .DIV_W (DIV_W),
    .VW    (CNT_W)
  ) u_div_h (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_h),
    .divisor_i  (fill_q),
    .busy_o     (div_h_busy),
    .quotient_o (quo_h)
  );

  // restore the sign: truncation toward zero falls out of dividing magnitudes
  assign avg_t_full = tneg_q ? (~quo_t + 1'b1) : quo_t;

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SUM;
      S_SUM:   state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (!div_t_busy && !div_h_busy) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      fill_q      <= '0;
      tsum_q      <= '0;
      hsum_q      <= '0;
      peak_t_q    <= '0;
      peak_h_q    <= '0;
      log_next_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SUM) begin
        pos_q      <= pos_d;
        fill_q     <= fill_d;
        tsum_q     <= tsum_d;
        hsum_q     <= hsum_d;
        peak_t_q   <= peak_t_d;
        peak_h_q   <= peak_h_d;
        log_next_q <= log_next_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture, hold, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q   <= in_i.temperature;
      h_q   <= in_i.humidity;
      alt_q <= in_i.altitude;
    end
    if (state_q == S_SUM) begin
      wr_q   <= log_hit;
      slot_q <= log_hit ? SLOT_W'(log_next_q) : '0;
    end
    if (state_q == S_START) begin
      tneg_q <= tsum_q[TS_W-1];
    end
    if (out_load) begin
      avg_t_q      <= signed'(avg_t_full[TEMP_W-1:0]);
      avg_h_q      <= quo_h[HUM_W-1:0];
      out_peak_t_q <= peak_t_q;
      out_peak_h_q <= peak_h_q;
      out_wr_q     <= wr_q;
      out_slot_q   <= slot_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.avg_temperature  = avg_t_q;
  assign out_o.avg_humidity     = avg_h_q;
  assign out_o.peak_temperature = out_peak_t_q;
  assign out_o.peak_humidity    = out_peak_h_q;
  assign out_o.log_written      = out_wr_q;
  assign out_o.log_slot         = out_slot_q;

endmodule

// ----- hw/rtl/swapl_chk.sv -----
// Port-level checker for the sensor window unit, bound to the top level.
// Depends on swapl_pkg and the top-level ports.
module swapl_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [swapl_pkg::TEMP_W-1:0] out_avg_t_i,
  input logic [swapl_pkg::HUM_W-1:0]        out_avg_h_i,
  input logic [swapl_pkg::PEAK_W-1:0]       out_peak_t_i,
  input logic [swapl_pkg::PEAK_W-1:0]       out_peak_h_i,
  input logic                               out_wr_i,
  input logic [swapl_pkg::SLOT_W-1:0]       out_slot_i
);
  import swapl_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_avg_t_i) && $stable(out_avg_h_i)
      && $stable(out_peak_t_i) && $stable(out_peak_h_i) && $stable(out_wr_i)
      && $stable(out_slot_i))
    else $error("stalled result word changed");

  // one sample word in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample word taken while busy");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_wr_i |-> out_slot_i == '0)
    else $error("log slot set without a log write");

endmodule

bind sensor_window_average_peak_log_unit swapl_chk u_swapl_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_avg_t_i  (out_o.avg_temperature),
  .out_avg_h_i  (out_o.avg_humidity),
  .out_peak_t_i (out_o.peak_temperature),
  .out_peak_h_i (out_o.peak_humidity),
  .out_wr_i     (out_o.log_written),
  .out_slot_i   (out_o.log_slot)
);
